>>> sv/biq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and term arithmetic for the biquad IIR filter.
// No dependencies.
package biq_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 33;

   localparam int SH_B0 = 24;
   localparam int SH_B1 = 23;
   localparam int SH_B2 = 24;
   localparam int SH_A1 = 14;
   localparam int SH_A2 = 15;

   localparam logic signed [PROD_W-1:0] RND_B0 = PROD_W'(1) << (SH_B0 - 1);
   localparam logic signed [PROD_W-1:0] RND_B1 = PROD_W'(1) << (SH_B1 - 1);
   localparam logic signed [PROD_W-1:0] RND_B2 = PROD_W'(1) << (SH_B2 - 1);
   localparam logic signed [PROD_W-1:0] RND_A1 = PROD_W'(1) << (SH_A1 - 1);
   localparam logic signed [PROD_W-1:0] RND_A2 = PROD_W'(1) << (SH_A2 - 1);

   localparam logic signed [COEF_W-1:0] RST_B0 = 16'sh76B0;
   localparam logic signed [COEF_W-1:0] RST_B1 = 16'sh76B0;
   localparam logic signed [COEF_W-1:0] RST_B2 = 16'sh76B0;
   localparam logic signed [COEF_W-1:0] RST_A1 = 16'sh74A7;
   localparam logic signed [COEF_W-1:0] RST_A2 = 16'sh94D7;

   localparam logic signed [SAMPLE_W-1:0] RST_X_HIST = 16'sh8001;
   localparam logic signed [SAMPLE_W-1:0] RST_Y_HIST = 16'shC000;

   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } queue_head_type;

   // round half up, arithmetic shift, keep the low sample bits
   function automatic logic signed [SAMPLE_W-1:0] term(
      input logic signed [COEF_W-1:0]   c,
      input logic signed [SAMPLE_W-1:0] s,
      input logic signed [PROD_W-1:0]   rnd,
      input int                         sh
   );
      logic signed [MUL_W-1:0]  mul;
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] shifted;
      mul     = c * s;
      prod    = PROD_W'(mul) + rnd;
      shifted = prod >>> sh;
      return shifted[SAMPLE_W-1:0];
   endfunction

endpackage

>>> sv/biq_csr.sv
`timescale 1ns / 1ps
// Coefficient registers behind the APB-style configuration port.
// Depends on biq_pkg.
module biq_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [biq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [biq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [biq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output biq_pkg::coef_type              coef
);
   import biq_pkg::*;

   coef_type      coef_ff;
   coef_type      coef_in;
   reg_index_type idx;
   logic          wr_en;
   logic signed [COEF_W-1:0] rd_val;
   logic signed [COEF_W-1:0] wr_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_val     = csr_pwdata[COEF_W-1:0];

   always_comb begin
      coef_in = coef_ff;
      rd_val  = '0;
      unique case (idx)
         REG_B0: begin
            rd_val = coef_ff.b0;
            if (wr_en) coef_in.b0 = wr_val;
         end
         REG_B1: begin
            rd_val = coef_ff.b1;
            if (wr_en) coef_in.b1 = wr_val;
         end
         REG_B2: begin
            rd_val = coef_ff.b2;
            if (wr_en) coef_in.b2 = wr_val;
         end
         REG_A1: begin
            rd_val = coef_ff.a1;
            if (wr_en) coef_in.a1 = wr_val;
         end
         REG_A2: begin
            rd_val = coef_ff.a2;
            if (wr_en) coef_in.a2 = wr_val;
         end
         default: begin
            rd_val = '0;
         end
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-COEF_W){rd_val[COEF_W-1]}}, rd_val};
   assign coef       = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= RST_B0;
         coef_ff.b1 <= RST_B1;
         coef_ff.b2 <= RST_B2;
         coef_ff.a1 <= RST_A1;
         coef_ff.a2 <= RST_A2;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

>>> sv/biq_front.sv
`timescale 1ns / 1ps
// Front end: accepts input samples into a short request queue.
// Depends on biq_pkg.
module biq_front #(
   parameter int QueueDepth = biq_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [biq_pkg::SAMPLE_W-1:0] req_x_sample,
   input  logic                                pop,
   output biq_pkg::queue_head_type             head
);
   import biq_pkg::*;

   localparam int PTR_W = $clog2(QueueDepth);
   localparam int CNT_W = $clog2(QueueDepth + 1);

   logic signed [SAMPLE_W-1:0] mem_ff [QueueDepth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             do_pop;

   assign req_ready   = count_ff != CNT_W'(QueueDepth);
   assign push        = req_valid & req_ready;
   assign head.valid  = count_ff != '0;
   assign head.sample = mem_ff[rd_ptr_ff];
   assign do_pop      = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_x_sample;
      end
   end

endmodule

>>> sv/biq_back.sv
`timescale 1ns / 1ps
// Back end: filter datapath, sample history and output register.
// Depends on biq_pkg.
module biq_back (
   input  logic                                clock,
   input  logic                                reset,
   input  biq_pkg::queue_head_type             head,
   output logic                                pop,
   input  biq_pkg::coef_type                   coef,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [biq_pkg::SAMPLE_W-1:0] rsp_y_sample
);
   import biq_pkg::*;

   logic signed [SAMPLE_W-1:0] x_hist_one_ff, x_hist_two_ff;
   logic signed [SAMPLE_W-1:0] y_hist_one_ff, y_hist_two_ff;
   logic signed [SAMPLE_W-1:0] rsp_y_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] t_b0, t_b1, t_b2, t_a1, t_a2;
   logic signed [SAMPLE_W-1:0] y_in;

   assign pop = head.valid & (~rsp_valid_ff | rsp_ready);

   assign t_b0 = term(coef.b0, head.sample,   RND_B0, SH_B0);
   assign t_b1 = term(coef.b1, x_hist_one_ff, RND_B1, SH_B1);
   assign t_b2 = term(coef.b2, x_hist_two_ff, RND_B2, SH_B2);
   assign t_a1 = term(coef.a1, y_hist_one_ff, RND_A1, SH_A1);
   assign t_a2 = term(coef.a2, y_hist_two_ff, RND_A2, SH_A2);
   // wraps to the sample width
   assign y_in = t_b0 + t_b1 + t_b2 + t_a1 + t_a2;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         x_hist_one_ff <= RST_X_HIST;
         x_hist_two_ff <= RST_X_HIST;
         y_hist_one_ff <= RST_Y_HIST;
         y_hist_two_ff <= RST_Y_HIST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            x_hist_one_ff <= head.sample;
            x_hist_two_ff <= x_hist_one_ff;
            y_hist_one_ff <= y_in;
            y_hist_two_ff <= y_hist_one_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_y_ff <= y_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_sample = rsp_y_ff;

endmodule

>>> sv/biquad_iir_fixed_point_unit.sv
`timescale 1ns / 1ps
// Biquad direct-form-1 IIR filter top level: request queue, filter back end, coefficient CSRs.
// Depends on biq_pkg, biq_csr, biq_front, biq_back.
//
//   channel   handshake              payload
//   req       req_valid/req_ready    req_x_sample
//   rsp       rsp_valid/rsp_ready    rsp_y_sample
//   csr       APB write/read         coef_b0..coef_a2 at 0x00..0x10
//
// One sample per cycle sustained while rsp_ready stays high; an accepted request is written
// into the queue, then popped into the output register, which raises rsp_valid.
// The clock is bound by the output feedback: a1 multiply on the previous output plus the
// five-term add, all in the cycle that pops the queue.
// Reset loads the default coefficients and the initial history and empties the queue.
// A stalled rsp side fills the queue; req_ready drops only when it is full.
module biquad_iir_fixed_point_unit #(
   parameter int QueueDepth = biq_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [biq_pkg::SAMPLE_W-1:0] req_x_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [biq_pkg::SAMPLE_W-1:0] rsp_y_sample,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [biq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [biq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [biq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import biq_pkg::*;

   coef_type       coef;
   queue_head_type head;
   logic           pop;

   biq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   biq_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_x_sample (req_x_sample),
      .pop          (pop),
      .head         (head)
   );

   biq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .coef         (coef),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_y_sample (rsp_y_sample)
   );

endmodule

>>> sim/tb_biquad_iir_fixed_point_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for biquad_iir_fixed_point_unit: directed rows, then random samples
// under several idle/stall mixes and coefficient sets, checked against a bit-exact predictor.
// Depends on biq_pkg and biquad_iir_fixed_point_unit.
module tb_biquad_iir_fixed_point_unit;
   import biq_pkg::*;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           index;
      logic [31:0]  value;
      bit           y_known;
      sample_type   y;
   } dir_row_type;

   localparam int UNMAPPED_INDEX  = 5;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int PRESSURE_PHASE  = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 10;

   localparam coef_type RESET_COEFS = '{b0: RST_B0, b1: RST_B1, b2: RST_B2,
                                        a1: RST_A1, a2: RST_A2};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sample_type                req_x_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   sample_type                rsp_y_sample;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // known result carried alongside the request payload
   bit                        req_y_known = 1'b0;
   sample_type                req_y_value = '0;

   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   bit                        rsp_hold = 1'b0;
   int                        error_count = 0;
   int                        quiet_cycles = 0;

   coef_type                  coef_now;
   sample_type                x_prev1, x_prev2, y_prev1, y_prev2;
   sample_type                expected_y_q[$];

   dir_row_type dir_rows [37] = '{
      '{ROW_SAMPLE, 0, -32767, 1'b1, -16383},
      '{ROW_SAMPLE, 0, 32767, 1'b0, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b0, 0},
      '{ROW_SAMPLE, 0, 0, 1'b0, 0},
      '{ROW_SAMPLE, 0, 1, 1'b0, 0},
      '{ROW_SAMPLE, 0, -1, 1'b0, 0},
      '{ROW_CONFIG, REG_B0, 32'h0000_7FFF, 1'b0, 0},
      '{ROW_CONFIG, REG_B1, 32'hFFFF_7FFF, 1'b0, 0},
      '{ROW_CONFIG, REG_B2, 32'h0000_7FFF, 1'b0, 0},
      '{ROW_CONFIG, REG_A1, 32'h5555_7FFF, 1'b0, 0},
      '{ROW_CONFIG, REG_A2, 32'h0000_7FFF, 1'b0, 0},
      '{ROW_SAMPLE, 0, 32767, 1'b0, 0},
      '{ROW_SAMPLE, 0, 32767, 1'b0, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b0, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b0, 0},
      '{ROW_CONFIG, REG_B0, 32'hFFFF_8000, 1'b0, 0},
      '{ROW_CONFIG, REG_B1, 32'h0000_8000, 1'b0, 0},
      '{ROW_CONFIG, REG_B2, 32'hAAAA_8000, 1'b0, 0},
      '{ROW_CONFIG, REG_A1, 32'h0000_8000, 1'b0, 0},
      '{ROW_CONFIG, REG_A2, 32'hFFFF_8000, 1'b0, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b0, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b0, 0},
      '{ROW_SAMPLE, 0, 32767, 1'b0, 0},
      '{ROW_CONFIG, REG_B0, 32'h1234_0000, 1'b0, 0},
      '{ROW_CONFIG, REG_B1, 32'h0000_0000, 1'b0, 0},
      '{ROW_CONFIG, REG_B2, 32'hFFFF_0000, 1'b0, 0},
      '{ROW_CONFIG, REG_A1, 32'h0000_0000, 1'b0, 0},
      '{ROW_CONFIG, REG_A2, 32'h8000_0000, 1'b0, 0},
      '{ROW_SAMPLE, 0, 32767, 1'b1, 0},
      '{ROW_SAMPLE, 0, -32768, 1'b1, 0},
      // unmapped register: write must not land anywhere
      '{ROW_CONFIG, UNMAPPED_INDEX, 32'h0000_7FFF, 1'b0, 0},
      '{ROW_SAMPLE, 0, 12345, 1'b1, 0},
      // b1 = 2^12 with +/-1024 puts the b1 term exactly on a rounding tie
      '{ROW_CONFIG, REG_B1, 32'hABCD_1000, 1'b0, 0},
      '{ROW_SAMPLE, 0, 1024, 1'b0, 0},
      '{ROW_SAMPLE, 0, -1024, 1'b0, 0},
      '{ROW_SAMPLE, 0, 0, 1'b0, 0},
      '{ROW_SAMPLE, 0, 0, 1'b0, 0}
   };

   biquad_iir_fixed_point_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_x_sample (req_x_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_y_sample (rsp_y_sample),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor((c * s + half) / 2^sh)
   function automatic longint rounded_product(input logic signed [15:0] c,
                                              input logic signed [15:0] s, input int sh);
      longint p;
      p = longint'(c) * longint'(s) + (longint'(1) << (sh - 1));
      return p >>> sh;
   endfunction

   function automatic sample_type biquad_output(input coef_type c, input sample_type x);
      longint acc;
      acc = rounded_product(c.b0, x, SH_B0) + rounded_product(c.b1, x_prev1, SH_B1)
          + rounded_product(c.b2, x_prev2, SH_B2) + rounded_product(c.a1, y_prev1, SH_A1)
          + rounded_product(c.a2, y_prev2, SH_A2);
      return sample_type'(acc[15:0]);
   endfunction

   function automatic logic [15:0] coef_field(input coef_type c, input int index);
      case (index)
         REG_B0:  return c.b0;
         REG_B1:  return c.b1;
         REG_B2:  return c.b2;
         REG_A1:  return c.a1;
         default: return c.a2;
      endcase
   endfunction

   function automatic logic [15:0] random_coef();
      case ($urandom_range(4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return 16'sh7FFF;
      if (pick < 10) return 16'sh8000;
      if (pick < 30) return sample_type'(int'($urandom_range(511)) - 256);
      return sample_type'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_sample(input sample_type x, input bit y_known,
                              input sample_type y_value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= x;
      req_y_known  <= y_known;
      req_y_value  <= y_value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_y_q.size() != 0);
   endtask

   task automatic csr_access(input bit is_write, input int index, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'(4 * index);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_coef(input int index, input logic [31:0] wdata);
      logic [31:0] rdata;
      csr_access(1'b1, index, wdata, rdata);
      if (index <= int'(REG_A2)) begin
         csr_access(1'b0, index, '0, rdata);
         if (rdata[15:0] !== wdata[15:0])
            report_mismatch("coefficient readback", int'(rdata[15:0]), int'(wdata[15:0]));
      end
   endtask

   // receiver: random stalls plus a forced hold-off
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // predictor and result checker
   always @(posedge clock) begin : predict
      sample_type y_next;
      sample_type y_want;
      if (reset) begin
         coef_now = RESET_COEFS;
         x_prev1  = RST_X_HIST;
         x_prev2  = RST_X_HIST;
         y_prev1  = RST_Y_HIST;
         y_prev2  = RST_Y_HIST;
         expected_y_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_y_q.size() == 0) begin
               report_mismatch("response with no request pending", int'(rsp_y_sample), 0);
            end else begin
               y_want = expected_y_q.pop_front();
               if (rsp_y_sample !== y_want)
                  report_mismatch("y_sample", int'(rsp_y_sample), int'(y_want));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_B0:  coef_now.b0 = csr_pwdata[15:0];
               REG_B1:  coef_now.b1 = csr_pwdata[15:0];
               REG_B2:  coef_now.b2 = csr_pwdata[15:0];
               REG_A1:  coef_now.a1 = csr_pwdata[15:0];
               REG_A2:  coef_now.a2 = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            y_next = biquad_output(coef_now, req_x_sample);
            expected_y_q.push_back(req_y_known ? req_y_value : y_next);
            x_prev2 = x_prev1;
            x_prev1 = req_x_sample;
            y_prev2 = y_prev1;
            y_prev1 = y_next;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] rdata;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = int'(REG_B0); i <= int'(REG_A2); i++) begin
         csr_access(1'b0, i, '0, rdata);
         if (rdata[15:0] !== coef_field(RESET_COEFS, i))
            report_mismatch("reset coefficient", int'(rdata[15:0]),
                            int'(coef_field(RESET_COEFS, i)));
      end

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CONFIG) begin
            drain_requests();
            write_coef(dir_rows[i].index, dir_rows[i].value);
         end else begin
            send_sample(sample_type'(dir_rows[i].value[15:0]), dir_rows[i].y_known,
                        dir_rows[i].y);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_requests();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 62; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 62; end
            default: begin send_idle_pct = 28; rsp_stall_pct <= 28; end
         endcase
         for (int r = int'(REG_B0); r <= int'(REG_A2); r++) begin
            if (phase == 0 || phase == PRESSURE_PHASE)
               write_coef(r, {16'($urandom), coef_field(RESET_COEFS, r)});
            else
               write_coef(r, {16'($urandom), random_coef()});
         end
         if (phase == PRESSURE_PHASE) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
               for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(random_sample(), 1'b0, '0);
            join
         end else begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_sample(random_sample(), 1'b0, '0);
         end
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
